// ===== hdl/drti_pkg.sv =====
// Package: shared constants, types and stage payloads for the round-to-integral pipeline
package drti_pkg;
  localparam int unsigned WordW = 64;
  localparam int unsigned FracW = 52;
  localparam int unsigned ExpW = 11;
  localparam logic [ExpW-1:0] ExpBias = 11'd1023;
  localparam logic [ExpW-1:0] ExpPass = 11'd1074;
  localparam logic [WordW-1:0] SignBit = 64'h8000_0000_0000_0000;
  localparam logic [WordW-1:0] OneBits = 64'h3FF0_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_FLOOR = 2'd0,
    OP_CEIL  = 2'd1,
    OP_TRUNC = 2'd2,
    OP_ROUND = 2'd3
  } op_t;

  // Stage 1 to stage 2: decoded operand
  typedef struct packed {
    logic [WordW-1:0] value;
    op_t              op;
    logic             pass;
    logic             below_one;
    logic [WordW-1:0] below_one_res;
    logic [WordW-1:0] unit;
  } dec_t;

  // Stage 2 to stage 3: increment decision and masked value
  typedef struct packed {
    logic             direct;
    logic [WordW-1:0] direct_res;
    logic [WordW-1:0] masked;
    logic [WordW-1:0] unit;
    logic             inc;
  } rnd_t;
endpackage

// ===== hdl/drti_if.sv =====
// Interface: valid/ready channel carrying one word
interface drti_if #(parameter int unsigned W = 64);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/drti_decode.sv =====
// Module: decode stage - exponent classify, sub-one result, unit weight
module drti_decode (
  input  logic [1:0]                   req_type,
  input  logic [drti_pkg::WordW-1:0]   value_bits,
  output drti_pkg::dec_t               dec
);
  import drti_pkg::*;

  logic [ExpW-1:0] biased;
  logic [ExpW-1:0] e;
  logic            neg;
  logic            nonzero;
  logic [WordW-1:0] sign;

  // Classify operand and build the below-one result
  always_comb begin
    biased  = value_bits[WordW-2 -: ExpW];
    neg     = value_bits[WordW-1];
    nonzero = |value_bits[WordW-2:0];
    sign    = neg ? SignBit : '0;
    e       = biased - ExpBias;
    dec.value = value_bits;
    dec.op    = op_t'(req_type);
    dec.pass  = biased > ExpPass;
    dec.below_one = biased < ExpBias;
    case (op_t'(req_type))
      OP_FLOOR: dec.below_one_res = (neg && nonzero) ? (SignBit | OneBits) : sign;
      OP_CEIL:  dec.below_one_res = (!neg && nonzero) ? OneBits : sign;
      OP_TRUNC: dec.below_one_res = sign;
      default:  dec.below_one_res = (biased == ExpBias - 11'd1) ? (sign | OneBits) : sign;
    endcase
    dec.unit = (WordW'(1) << (FracW - 32'(e[5:0])));
  end
endmodule

// ===== hdl/drti_round.sv =====
// Module: rounding stage - fraction test, increment decision, mask
module drti_round (
  input  drti_pkg::dec_t dec,
  output drti_pkg::rnd_t rnd
);
  import drti_pkg::*;

  logic [WordW-1:0] below;
  logic [WordW-1:0] frac;

  // Decide on an increment and clear fraction bits
  always_comb begin
    below = dec.unit - WordW'(1);
    frac  = dec.value & below;
    rnd.unit   = dec.unit;
    rnd.masked = dec.value & ~below;
    rnd.direct = dec.pass || dec.below_one || (frac == '0);
    rnd.direct_res = dec.below_one ? dec.below_one_res : dec.value;
    case (dec.op)
      OP_FLOOR: rnd.inc = dec.value[WordW-1];
      OP_CEIL:  rnd.inc = !dec.value[WordW-1];
      OP_TRUNC: rnd.inc = 1'b0;
      default:  rnd.inc = |(frac & (dec.unit >> 1));
    endcase
  end
endmodule

// ===== hdl/double_round_to_integral.sv =====
// Top level: three-stage round-to-integral pipeline for binary64 words
// Takes one word per cycle and passes each through the decode, round and
// add registers in turn; the stages advance together under one
// enable, so a stall on the result side holds every stage and throughput
// is one word per cycle whenever the consumer is ready. The input word
// carries the operation code in its top two bits above the operand.
module double_round_to_integral (
  input logic   clk,
  input logic   rst,
  drti_if.sink   in_ch,
  drti_if.source out_ch
);
  import drti_pkg::*;

  logic       v1, v2, v3;
  logic       adv;
  dec_t       dec_c, dec;
  rnd_t       rnd_c, rnd;
  logic [WordW-1:0] res;

  // Advance all stages when the output register is free or taken
  assign adv = !v3 || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = v3;
  assign out_ch.data = res;

  drti_decode u_dec (
    .req_type  (in_ch.data[WordW+1:WordW]),
    .value_bits(in_ch.data[WordW-1:0]),
    .dec       (dec_c)
  );

  drti_round u_rnd (.dec(dec), .rnd(rnd_c));

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_ch.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      dec <= dec_c;
      rnd <= rnd_c;
      res <= rnd.direct ? rnd.direct_res
                        : ((rnd.masked + (rnd.inc ? rnd.unit : '0)));
    end
  end

  // Output holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !out_ch.ready |=> v3 && $stable(res))
    else $error("result dropped during stall");
  // An accepted word reaches the output register if the stages keep advancing
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready ##1 adv ##1 adv |=> v3)
    else $error("word lost in pipeline");
  // Ready follows output state
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !v3 |-> in_ch.ready)
    else $error("input stalled with empty output");
endmodule
